>>> src/flywheel_speed_pid_top_macros.svh
// ----------------------------------------------------------------------------
// flywheel_speed_pid_top_macros.svh
// Assertion macros used by the flywheel speed loop sequencer (fsp_ctrl).
// ----------------------------------------------------------------------------
`ifndef FLYWHEEL_SPEED_PID_TOP_MACROS_SVH
`define FLYWHEEL_SPEED_PID_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define FSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define FSP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSP_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> src/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and fixed constants of the flywheel speed loop.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [2:0] REG_TARGET      = 3'd4;

  localparam logic [31:0] PROP_GAIN_RST   = 32'd1760936;
  localparam logic [31:0] INTEG_GAIN_RST  = 32'd9019;
  localparam logic [31:0] DERIV_GAIN_RST  = 32'd644670;
  localparam logic [30:0] INTEG_LIMIT_RST = 31'd476190;
  localparam logic [14:0] TARGET_RST      = 15'd9501;

  // term widths: gains are 32 fractional bits
  localparam int PROD_W = 66;
  localparam int ACC_W  = 56;
  localparam int DRV_SHIFT = 17;

  localparam logic signed [PROD_W-1:0] P_TERM_MAX = 66'sd3221225472;     // 0.75
  localparam logic signed [PROD_W-1:0] I_TERM_MAX = 66'sd4503599627370496; // 2^52
  localparam logic signed [18:0] DCHG_MAX = 19'sd131071;
  localparam logic signed [15:0] DRIVE_MAX = 16'sd32767;

  // multiplier operand select
  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_I = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;

  // accumulator operation
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_LOAD_P = 2'd1;
  localparam logic [1:0] ACC_ADD_I  = 2'd2;
  localparam logic [1:0] ACC_ADD_D  = 2'd3;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integ_gain;
    logic [31:0] deriv_gain;
    logic [30:0] integ_limit;
    logic [14:0] target_speed;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       ld_in;
    logic       clr_flt;
    logic       mem_rd;
    logic       ring_upd;
    logic       div_init;
    logic       div_step;
    logic       err_ld;
    logic       pid_upd;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run;
    logic restart;
  } sts_t;

endpackage

>>> src/fsp_in_if.sv
// ----------------------------------------------------------------------------
// fsp_in_if
// Sample channel: one speed sample word per control tick.
// ----------------------------------------------------------------------------
interface fsp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_speed;
  logic        [14:0] speed_scale;
  logic               run_request;
  logic               restart;

  modport source (output valid, output measured_speed, output speed_scale,
                  output run_request, output restart, input ready);
  modport sink (input valid, input measured_speed, input speed_scale,
                input run_request, input restart, output ready);
endinterface

>>> src/fsp_out_if.sv
// ----------------------------------------------------------------------------
// fsp_out_if
// Result channel: drive command and loop observables, one word per tick.
// ----------------------------------------------------------------------------
interface fsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_drive;
  logic signed [15:0] filtered_speed;
  logic signed [17:0] error_change;

  modport source (output valid, output motor_drive, output filtered_speed,
                  output error_change, input ready);
  modport sink (input valid, input motor_drive, input filtered_speed,
                input error_change, output ready);
endinterface

>>> src/flywheel_speed_pid_top.sv
// ----------------------------------------------------------------------------
// flywheel_speed_pid_top
// Flywheel speed loop: moving-average filter and clamped PID drive.
//
//   channel   dir  word                                           handshake
//   in_ch     in   measured_speed, speed_scale, run_request,      valid/ready
//                  restart
//   out_ch    out  motor_drive, filtered_speed, error_change      valid/ready
//   cfg_*     in   APB: gains, integral limit, target speed       pready = 1
//
// A running tick loads its result word after the ring read and update, the
// reciprocal product and correction divider steps, and three shared-multiplier
// passes for the P, I and D terms. An idle tick goes from the prepare state
// straight to the result load. The next word is taken in the cycle after the
// load; the sequencer waits only while the output register is still full.
// Synchronous active-low reset.
// ----------------------------------------------------------------------------
module flywheel_speed_pid_top #(
  parameter int FILTER_DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fsp_in_if.sink                     in_ch,
  fsp_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fsp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fsp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fsp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  fsp_pkg::cfg_t cfg;
  fsp_pkg::cmd_t cmd;
  fsp_pkg::sts_t sts;

  // configuration registers
  fsp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // tick sequencer
  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // filter and PID arithmetic
  fsp_datapath #(
    .FILTER_DEPTH (FILTER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .measured_speed (in_ch.measured_speed),
    .speed_scale    (in_ch.speed_scale),
    .run_request    (in_ch.run_request),
    .restart        (in_ch.restart),
    .motor_drive    (out_ch.motor_drive),
    .filtered_speed (out_ch.filtered_speed),
    .error_change   (out_ch.error_change)
  );

endmodule

>>> src/fsp_regs.sv
// ----------------------------------------------------------------------------
// fsp_regs
// APB register bank holding gains, integral clamp and target speed.
// ----------------------------------------------------------------------------
module fsp_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [fsp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fsp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fsp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output fsp_pkg::cfg_t             cfg
);

  fsp_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= fsp_pkg::PROP_GAIN_RST;
      cfg_r.integ_gain   <= fsp_pkg::INTEG_GAIN_RST;
      cfg_r.deriv_gain   <= fsp_pkg::DERIV_GAIN_RST;
      cfg_r.integ_limit  <= fsp_pkg::INTEG_LIMIT_RST;
      cfg_r.target_speed <= fsp_pkg::TARGET_RST;
    end else if (wr_en) begin
      case (reg_idx)
        fsp_pkg::REG_PROP_GAIN:   cfg_r.prop_gain    <= cfg_pwdata;
        fsp_pkg::REG_INTEG_GAIN:  cfg_r.integ_gain   <= cfg_pwdata;
        fsp_pkg::REG_DERIV_GAIN:  cfg_r.deriv_gain   <= cfg_pwdata;
        fsp_pkg::REG_INTEG_LIMIT: cfg_r.integ_limit  <= cfg_pwdata[30:0];
        fsp_pkg::REG_TARGET:      cfg_r.target_speed <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      fsp_pkg::REG_PROP_GAIN:   cfg_prdata = cfg_r.prop_gain;
      fsp_pkg::REG_INTEG_GAIN:  cfg_prdata = cfg_r.integ_gain;
      fsp_pkg::REG_DERIV_GAIN:  cfg_prdata = cfg_r.deriv_gain;
      fsp_pkg::REG_INTEG_LIMIT: cfg_prdata = {1'b0, cfg_r.integ_limit};
      fsp_pkg::REG_TARGET:      cfg_prdata = {17'd0, cfg_r.target_speed};
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

>>> src/fsp_datapath.sv
// ----------------------------------------------------------------------------
// fsp_datapath
// Sample ring, reciprocal average divider, shared gain multiplier, PID terms.
// ----------------------------------------------------------------------------
module fsp_datapath #(
  parameter int FILTER_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fsp_pkg::cmd_t      cmd,
  output fsp_pkg::sts_t      sts,
  input  fsp_pkg::cfg_t      cfg,
  input  logic signed [15:0] measured_speed,
  input  logic        [14:0] speed_scale,
  input  logic               run_request,
  input  logic               restart,
  output logic signed [15:0] motor_drive,
  output logic signed [15:0] filtered_speed,
  output logic signed [17:0] error_change
);

  localparam int PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SUM_W = 16 + $clog2(FILTER_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FILTER_DEPTH - 1);
  localparam logic [SUM_W-1:0] BIAS     = SUM_W'(FILTER_DEPTH * 32768);
  localparam logic [SUM_W-1:0] DIV_N    = SUM_W'(FILTER_DEPTH);
  // floor(2^SUM_W / depth): the quotient estimate is low by at most one
  localparam logic [SUM_W:0]   RECIP    = (SUM_W + 1)'((longint'(1) <<< SUM_W) / FILTER_DEPTH);
  localparam int ACC_W = fsp_pkg::ACC_W;
  localparam int PROD_W = fsp_pkg::PROD_W;

  // latched input word
  logic signed [15:0] sample_r;
  logic        [14:0] scale_r;
  logic               run_r;
  logic               restart_r;

  // sample ring
  logic signed [15:0]      ring_mem [FILTER_DEPTH];
  logic [FILTER_DEPTH-1:0] vld_r;
  logic [PTR_W-1:0]        ptr_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [15:0]      rd_data_r;
  logic                    rd_vld_r;
  logic signed [15:0]      old_smp;
  logic signed [SUM_W:0]   sum_wide;

  // divider
  logic [SUM_W-1:0] du_r;
  logic [2*SUM_W:0] rcp_prod;
  logic [15:0]      qe_r;
  logic [SUM_W-1:0] qe_back;
  logic [SUM_W-1:0] rem_e;
  logic [15:0]      quo_r;

  // error and PID state
  logic        [29:0] des_prod;
  logic        [15:0] desired_r;
  logic signed [15:0] avg_r;
  logic signed [15:0] avg_nxt;
  logic signed [17:0] err_r;
  logic signed [17:0] err_nxt;
  logic signed [31:0] intg_r;
  logic signed [17:0] prev_r;
  logic signed [17:0] dchg_r;
  logic signed [32:0] intg_sum;
  logic signed [32:0] intg_lim;
  logic signed [32:0] intg_nxt;
  logic signed [18:0] diff;
  logic signed [18:0] aerr;
  logic signed [18:0] dz;
  logic signed [18:0] dchg_nxt;

  // multiplier and accumulator
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] p_clamp;
  logic signed [PROD_W-1:0] i_clamp;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-fsp_pkg::DRV_SHIFT-1:0] drv_sh;
  logic signed [15:0]       drv;

  assign sts.run     = run_r;
  assign sts.restart = restart_r;

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      sample_r  <= measured_speed;
      scale_r   <= speed_scale;
      run_r     <= run_request;
      restart_r <= restart;
    end
  end

  // ring storage: registered read, single write port
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data_r <= ring_mem[ptr_r];
    end
    if (cmd.ring_upd) begin
      ring_mem[ptr_r] <= sample_r;
    end
  end

  // an entry never written since the last clear reads as zero
  assign old_smp  = rd_vld_r ? rd_data_r : 16'sd0;
  assign sum_wide = (SUM_W + 1)'(sum_r) - (SUM_W + 1)'(old_smp) + (SUM_W + 1)'(sample_r);

  // ring control: valid bits, write pointer, running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ptr_r    <= '0;
      sum_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_flt) begin
        vld_r <= '0;
        ptr_r <= '0;
        sum_r <= '0;
      end else if (cmd.ring_upd) begin
        vld_r[ptr_r] <= 1'b1;
        ptr_r        <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        sum_r        <= sum_wide[SUM_W-1:0];
      end
      if (cmd.mem_rd) begin
        rd_vld_r <= vld_r[ptr_r];
      end
    end
  end

  // desired speed = target * scale in Q1.14
  assign des_prod = cfg.target_speed * scale_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      desired_r <= des_prod[29:14];
    end
  end

  // floor average: biased dividend, reciprocal estimate then one correction
  assign rcp_prod = du_r * RECIP;
  assign qe_back  = SUM_W'(qe_r) * DIV_N;
  assign rem_e    = du_r - qe_back;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      du_r <= sum_r + BIAS;
    end else if (cmd.div_step) begin
      qe_r  <= rcp_prod[SUM_W+15:SUM_W];
      quo_r <= (rem_e >= DIV_N) ? qe_r + 16'd1 : qe_r;
    end
  end

  // quotient carries the bias of 2^15: flip the top bit
  assign avg_nxt = {~quo_r[15], quo_r[14:0]};
  assign err_nxt = $signed({2'b00, desired_r}) - 18'(avg_nxt);

  always_ff @(posedge clk) begin
    if (cmd.err_ld) begin
      avg_r <= avg_nxt;
      err_r <= err_nxt;
    end
  end

  // integral clamp and error change
  assign intg_sum = 33'(intg_r) + 33'(err_r);
  assign intg_lim = $signed({2'b00, cfg.integ_limit});

  always_comb begin
    if (intg_sum > intg_lim) begin
      intg_nxt = intg_lim;
    end else if (intg_sum < -intg_lim) begin
      intg_nxt = -intg_lim;
    end else begin
      intg_nxt = intg_sum;
    end
  end

  assign diff = 19'(err_r) - 19'(prev_r);
  assign aerr = err_r[17] ? -19'(err_r) : 19'(err_r);
  // first swing toward the target gives no derivative kick
  assign dz   = (diff >= aerr) ? 19'sd0 : diff;

  always_comb begin
    if (dz > fsp_pkg::DCHG_MAX) begin
      dchg_nxt = fsp_pkg::DCHG_MAX;
    end else if (dz < -fsp_pkg::DCHG_MAX) begin
      dchg_nxt = -fsp_pkg::DCHG_MAX;
    end else begin
      dchg_nxt = dz;
    end
  end

  // shared gain multiplier, operand chosen per step
  always_comb begin
    case (cmd.mul_sel)
      fsp_pkg::MUL_P: begin
        mul_a = $signed({1'b0, cfg.prop_gain});
        mul_b = 33'(err_r);
      end
      fsp_pkg::MUL_I: begin
        mul_a = $signed({1'b0, cfg.integ_gain});
        mul_b = 33'(intg_r);
      end
      fsp_pkg::MUL_D: begin
        mul_a = $signed({1'b0, cfg.deriv_gain});
        mul_b = 33'(dchg_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // term clamps
  always_comb begin
    if (prod_r > fsp_pkg::P_TERM_MAX) begin
      p_clamp = fsp_pkg::P_TERM_MAX;
    end else if (prod_r < -fsp_pkg::P_TERM_MAX) begin
      p_clamp = -fsp_pkg::P_TERM_MAX;
    end else begin
      p_clamp = prod_r;
    end
    if (prod_r > fsp_pkg::I_TERM_MAX) begin
      i_clamp = fsp_pkg::I_TERM_MAX;
    end else if (prod_r < -fsp_pkg::I_TERM_MAX) begin
      i_clamp = -fsp_pkg::I_TERM_MAX;
    end else begin
      i_clamp = prod_r;
    end
  end

  // term accumulator
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      fsp_pkg::ACC_LOAD_P: acc_r <= p_clamp[ACC_W-1:0];
      fsp_pkg::ACC_ADD_I:  acc_r <= acc_r + i_clamp[ACC_W-1:0];
      fsp_pkg::ACC_ADD_D:  acc_r <= acc_r + prod_r[ACC_W-1:0];
      default:             acc_r <= acc_r;
    endcase
  end

  // drive: floor shift to Q1.15 then saturate
  assign drv_sh = acc_r[ACC_W-1:fsp_pkg::DRV_SHIFT];

  always_comb begin
    if (drv_sh > (ACC_W - fsp_pkg::DRV_SHIFT)'(fsp_pkg::DRIVE_MAX)) begin
      drv = fsp_pkg::DRIVE_MAX;
    end else if (drv_sh < -(ACC_W - fsp_pkg::DRV_SHIFT)'(fsp_pkg::DRIVE_MAX)) begin
      drv = -fsp_pkg::DRIVE_MAX;
    end else begin
      drv = drv_sh[15:0];
    end
  end

  // integral, previous error and error change; integral cleared on an idle or restart tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intg_r <= '0;
      prev_r <= '0;
      dchg_r <= '0;
    end else begin
      if (cmd.pid_upd) begin
        intg_r <= intg_nxt[31:0];
        prev_r <= err_r;
        dchg_r <= dchg_nxt[17:0];
      end else if (cmd.out_ld && (!run_r || restart_r)) begin
        intg_r <= '0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      motor_drive    <= (run_r && !restart_r) ? drv : 16'sd0;
      filtered_speed <= run_r ? avg_r : 16'sd0;
      error_change   <= run_r ? dchg_r : 18'sd0;
    end
  end

endmodule

>>> src/fsp_ctrl.sv
// ----------------------------------------------------------------------------
// fsp_ctrl
// Sequencer for one control tick and the result word handshake.
// ----------------------------------------------------------------------------
`include "flywheel_speed_pid_top_macros.svh"

module fsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output fsp_pkg::cmd_t cmd,
  input  fsp_pkg::sts_t sts
);

  // two divider steps: reciprocal product, then remainder correction
  localparam int CW    = 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_READ = 4'd2;
  localparam logic [3:0] ST_UPD  = 4'd3;
  localparam logic [3:0] ST_DIVI = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_ERR  = 4'd6;
  localparam logic [3:0] ST_MP   = 4'd7;
  localparam logic [3:0] ST_MI   = 4'd8;
  localparam logic [3:0] ST_MD   = 4'd9;
  localparam logic [3:0] ST_SUM  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  logic [3:0]    state_r;
  logic [3:0]    state_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel = fsp_pkg::MUL_P;
    cmd.acc_op  = fsp_pkg::ACC_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.clr_flt = sts.restart;
        state_nxt   = sts.run ? ST_READ : ST_FIN;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err_ld = 1'b1;
        state_nxt  = ST_MP;
      end
      ST_MP: begin
        cmd.pid_upd = 1'b1;
        cmd.mul_sel = fsp_pkg::MUL_P;
        state_nxt   = ST_MI;
      end
      ST_MI: begin
        cmd.mul_sel = fsp_pkg::MUL_I;
        cmd.acc_op  = fsp_pkg::ACC_LOAD_P;
        state_nxt   = ST_MD;
      end
      ST_MD: begin
        cmd.mul_sel = fsp_pkg::MUL_D;
        cmd.acc_op  = fsp_pkg::ACC_ADD_I;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.acc_op = fsp_pkg::ACC_ADD_D;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        // wait here while the previous word is still unclaimed
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `FSP_ASSERT(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_r == ST_PREP), "accepted word did not start a tick")
  `FSP_NEVER(a_no_overwrite, clk, rst_n, cmd.out_ld && out_valid_r && !out_ready, "result word overwritten before taken")
  `FSP_ASSERT(a_div_done, clk, rst_n, (state_r == ST_ERR) |-> ($past(state_r) == ST_DIV && $past(cnt_r) == CNT_LAST), "average read before divider finished")
  `FSP_ASSERT(a_ld_only_fin, clk, rst_n, cmd.out_ld |=> (out_valid_r && state_r == ST_IDLE), "result load did not raise valid")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flywheel speed loop. An in-bench scoreboard
// tracks the averaging ring, the integral and the last error, and predicts
// the drive word for every sample word taken. Register setups are changed
// only while the loop is drained. Sample and result channels idle in random
// bursts, except in the final phase.
// ----------------------------------------------------------------------------

localparam int RING_DEPTH = 8;

// term limits, 32 fractional bits
localparam longint P_LIMIT     = 64'sd3 <<< 30;
localparam longint I_LIMIT     = 64'sd1 <<< 52;
localparam longint CHG_LIMIT   = 64'sd131071;
localparam longint DRIVE_LIMIT = 64'sd32767;
localparam longint DRIVE_DIV   = 64'sd1 <<< 17;

typedef struct {
  logic signed [15:0] measured_speed;
  logic        [14:0] speed_scale;
  logic               run_request;
  logic               restart;
} tick_word_t;

typedef struct {
  logic signed [15:0] motor_drive;
  logic signed [15:0] filtered_speed;
  logic signed [17:0] error_change;
} drive_word_t;

function automatic longint clamp_to(longint v, longint lo, longint hi);
  return (v < lo) ? lo : ((v > hi) ? hi : v);
endfunction

// division rounding toward minus infinity
function automatic longint floor_div(longint n, longint d);
  return (n >= 0) ? n / d : -((-n + d - 1) / d);
endfunction

class speed_loop_scoreboard;
  logic        [31:0] prop_gain;
  logic        [31:0] integ_gain;
  logic        [31:0] deriv_gain;
  logic        [30:0] integ_limit;
  logic        [14:0] target_speed;
  logic signed [15:0] ring [RING_DEPTH];
  int unsigned        ring_ptr;
  logic signed [18:0] ring_sum;
  logic signed [31:0] integral;
  logic signed [17:0] prev_err;
  drive_word_t        expected_q[$];
  int                 fails;

  function new();
    prop_gain    = fsp_pkg::PROP_GAIN_RST;
    integ_gain   = fsp_pkg::INTEG_GAIN_RST;
    deriv_gain   = fsp_pkg::DERIV_GAIN_RST;
    integ_limit  = fsp_pkg::INTEG_LIMIT_RST;
    target_speed = fsp_pkg::TARGET_RST;
    clear_ring();
    integral   = '0;
    prev_err   = '0;
    fails      = 0;
  endfunction

  function void clear_ring();
    foreach (ring[i]) ring[i] = '0;
    ring_ptr = 0;
    ring_sum = '0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      fsp_pkg::REG_PROP_GAIN:   prop_gain = value;
      fsp_pkg::REG_INTEG_GAIN:  integ_gain = value;
      fsp_pkg::REG_DERIV_GAIN:  deriv_gain = value;
      fsp_pkg::REG_INTEG_LIMIT: integ_limit = value[30:0];
      fsp_pkg::REG_TARGET:      target_speed = value[14:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      fsp_pkg::REG_PROP_GAIN:   return prop_gain;
      fsp_pkg::REG_INTEG_GAIN:  return integ_gain;
      fsp_pkg::REG_DERIV_GAIN:  return deriv_gain;
      fsp_pkg::REG_INTEG_LIMIT: return 32'(integ_limit);
      fsp_pkg::REG_TARGET:      return 32'(target_speed);
      default:                  return '0;
    endcase
  endfunction

  // one mismatch line, capped so a broken block cannot flood the log
  task report(string msg);
    if (fails < 100) $display("[%0t] MISMATCH %s", $time, msg);
    fails++;
  endtask

  // advance the loop state by one taken sample word, queue its drive word
  function void note_tick(tick_word_t w);
    longint acc, avg, desired, err, pterm, iterm, diff, mag, chg, total, drive;
    drive_word_t want;
    avg   = 0;
    chg   = 0;
    drive = 0;
    if (w.restart) clear_ring();
    if (w.run_request) begin
      // moving average over the ring
      acc = longint'(ring_sum) - longint'(ring[ring_ptr]) + longint'(w.measured_speed);
      ring_sum = acc[18:0];
      ring[ring_ptr] = w.measured_speed;
      ring_ptr = (ring_ptr + 1 == RING_DEPTH) ? 0 : ring_ptr + 1;
      avg = floor_div(longint'(ring_sum), RING_DEPTH);

      desired = (longint'(target_speed) * longint'(w.speed_scale)) >>> 14;
      err = desired - avg;
      pterm = clamp_to(longint'(prop_gain) * err, -P_LIMIT, P_LIMIT);

      // integral is clamped every running tick, whatever the gain
      acc = clamp_to(longint'(integral) + err, -longint'(integ_limit),
                     longint'(integ_limit));
      integral = acc[31:0];
      iterm = clamp_to(longint'(integ_gain) * longint'(integral), -I_LIMIT, I_LIMIT);

      // error change dropped when it reaches |error|, then saturated
      diff = err - longint'(prev_err);
      mag = (err < 0) ? -err : err;
      if (diff >= mag) diff = 0;
      chg = clamp_to(diff, -CHG_LIMIT, CHG_LIMIT);

      total = pterm + iterm + longint'(deriv_gain) * chg;
      drive = clamp_to(floor_div(total, DRIVE_DIV), -DRIVE_LIMIT, DRIVE_LIMIT);
      prev_err = err[17:0];
    end else begin
      integral = '0;
    end
    if (w.restart) begin
      integral = '0;
      drive = 0;
    end
    want.motor_drive    = drive[15:0];
    want.filtered_speed = avg[15:0];
    want.error_change   = chg[17:0];
    expected_q.push_back(want);
  endfunction

  task check_word(drive_word_t got);
    drive_word_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("word with nothing pending: drive %0d avg %0d chg %0d",
                       got.motor_drive, got.filtered_speed, got.error_change));
      return;
    end
    want = expected_q.pop_front();
    if (got.motor_drive !== want.motor_drive)
      report($sformatf("motor_drive %0d, expected %0d", got.motor_drive, want.motor_drive));
    if (got.filtered_speed !== want.filtered_speed)
      report($sformatf("filtered_speed %0d, expected %0d",
                       got.filtered_speed, want.filtered_speed));
    if (got.error_change !== want.error_change)
      report($sformatf("error_change %0d, expected %0d", got.error_change, want.error_change));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [fsp_pkg::CFG_AW-1:0] cfg_paddr;
  logic [fsp_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [fsp_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;
  bit                         calm;

  fsp_in_if  in_ch();
  fsp_out_if out_ch();
  speed_loop_scoreboard sb;

  flywheel_speed_pid_top #(.FILTER_DEPTH(RING_DEPTH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts, none once calm
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // check every result word taken
  always @(posedge clk) begin
    drive_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.motor_drive    = out_ch.motor_drive;
      got.filtered_speed = out_ch.filtered_speed;
      got.error_change   = out_ch.error_change;
      sb.check_word(got);
    end
  end

  // APB setup + access, then an idle phase; reads are compared with the shadow copy
  task automatic reg_access(input bit wr, input logic [2:0] idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr)
      sb.set_reg(idx, data);
    else if (cfg_prdata !== sb.reg_value(idx))
      sb.report($sformatf("register %0d reads %h, expected %h",
                          idx, cfg_prdata, sb.reg_value(idx)));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    reg_access(1'b1, idx, data);
    reg_access(1'b0, idx, '0);
  endtask

  // present one sample word, hold until taken, then maybe idle a burst
  task automatic send_tick(input tick_word_t w);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.measured_speed <= w.measured_speed;
    in_ch.speed_scale    <= w.speed_scale;
    in_ch.run_request    <= w.run_request;
    in_ch.restart        <= w.restart;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(w);
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(input int speed, input int scale, input bit run,
                             input bit restart_bit);
    tick_word_t w;
    w.measured_speed = speed[15:0];
    w.speed_scale    = scale[14:0];
    w.run_request    = run;
    w.restart        = restart_bit;
    send_tick(w);
  endtask

  // stop sending and wait for every pending drive word
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // mostly samples near the commanded speed, some full-range noise and edge values
  function automatic tick_word_t random_tick();
    tick_word_t w;
    longint cruise;
    int pick;
    w.speed_scale = ($urandom_range(0, 9) < 7) ? 15'($urandom_range(14000, 18000))
                                               : 15'($urandom_range(0, 32767));
    w.run_request = ($urandom_range(0, 9) != 0);
    w.restart     = ($urandom_range(0, 24) == 0);
    cruise = (longint'(sb.target_speed) * longint'(w.speed_scale)) >>> 14;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      cruise = clamp_to(cruise + int'($urandom_range(0, 600)) - 300, -32768, 32767);
      w.measured_speed = cruise[15:0];
    end else if (pick < 9) begin
      w.measured_speed = 16'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       w.measured_speed = 16'sh8000;
        1:       w.measured_speed = 16'sh7FFF;
        default: w.measured_speed = '0;
      endcase
    end
    return w;
  endfunction

  // one register setup per phase, extremes included
  task automatic apply_setting(input int k);
    logic [31:0] pg, ig, dg, il, ts;
    case (k)
      0: begin
        pg = $urandom_range(0, 8000000);
        ig = $urandom_range(0, 40000);
        dg = $urandom_range(0, 2000000);
        il = $urandom_range(1000, 1000000);
        ts = $urandom_range(5000, 15000);
      end
      1: begin
        pg = 32'hFFFF_FFFF;
        ig = 32'hFFFF_FFFF;
        dg = 32'hFFFF_FFFF;
        il = 32'h7FFF_FFFF;
        ts = 32'd32767;
      end
      2: begin
        pg = '0;
        ig = '0;
        dg = '0;
        il = '0;
        ts = '0;
      end
      3: begin
        pg = $urandom;
        ig = $urandom;
        dg = $urandom;
        il = $urandom & 32'h7FFF_FFFF;
        ts = $urandom_range(0, 32767);
      end
      4: begin
        pg = $urandom_range(0, 4000000);
        ig = 32'hFFFF_FFFF;
        dg = 32'hFFFF_FFFF;
        il = $urandom_range(0, 200);
        ts = $urandom_range(0, 32767);
      end
      default: begin
        pg = fsp_pkg::PROP_GAIN_RST;
        ig = fsp_pkg::INTEG_GAIN_RST;
        dg = fsp_pkg::DERIV_GAIN_RST;
        il = 32'(fsp_pkg::INTEG_LIMIT_RST);
        ts = 32'(fsp_pkg::TARGET_RST);
      end
    endcase
    write_reg(fsp_pkg::REG_PROP_GAIN, pg);
    write_reg(fsp_pkg::REG_INTEG_GAIN, ig);
    write_reg(fsp_pkg::REG_DERIV_GAIN, dg);
    write_reg(fsp_pkg::REG_INTEG_LIMIT, il);
    write_reg(fsp_pkg::REG_TARGET, ts);
  endtask

  initial begin
    sb = new();
    calm                 = 1'b0;
    rst_n                = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    in_ch.valid          = 1'b0;
    in_ch.measured_speed = '0;
    in_ch.speed_scale    = '0;
    in_ch.run_request    = 1'b0;
    in_ch.restart        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of every register
    for (int i = fsp_pkg::REG_PROP_GAIN; i <= fsp_pkg::REG_TARGET; i++)
      reg_access(1'b0, i[2:0], '0);

    // directed words at the reset setup
    send_fields(9501, 16384, 1'b1, 1'b0);
    send_fields(32767, 32767, 1'b1, 1'b0);
    send_fields(-32768, 0, 1'b1, 1'b0);
    send_fields(0, 16384, 1'b1, 1'b0);
    send_fields(1234, 16384, 1'b0, 1'b0);   // idle: ring and last error kept
    send_fields(9000, 16384, 1'b1, 1'b0);
    send_fields(9501, 16384, 1'b1, 1'b1);   // restart while running
    send_fields(9400, 16384, 1'b1, 1'b0);
    send_fields(9450, 16384, 1'b1, 1'b0);
    send_fields(-1, 21000, 1'b0, 1'b1);     // restart while idle
    send_fields(9501, 16384, 1'b1, 1'b0);
    send_fields(9600, 16384, 1'b1, 1'b0);
    send_fields(9520, 16384, 1'b1, 1'b0);
    // ring full of the most negative sample
    repeat (RING_DEPTH) send_fields(-32768, 32767, 1'b1, 1'b0);
    send_fields(32767, 32767, 1'b1, 1'b1);

    // random phases, one setup each; the last one without idling
    for (int k = 0; k < 6; k++) begin
      drain();
      calm = (k == 5);
      apply_setting(k);
      for (int n = 0; n < 80; n++) begin
        if (k == 1 && n == 40) drain();
        send_tick(random_tick());
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/fsp_pkg.sv
src/fsp_in_if.sv
src/fsp_out_if.sv
src/fsp_regs.sv
src/fsp_datapath.sv
src/fsp_ctrl.sv
src/flywheel_speed_pid_top.sv
bench/tb.sv
